FILE: hdl/ebml_pkg.sv
package ebml_pkg;

  localparam int EBML_MAX_DEPTH = 8;

  localparam int POS_W   = 64;
  localparam int ACC_W   = 56;
  localparam int ID_W    = 32;
  localparam int TIME_W  = 32;
  localparam int LEFT_W  = 3;

  // element IDs, marker bits kept
  localparam logic [ID_W-1:0] ID_BLOCK_GROUP  = 32'h0000_00a0;
  localparam logic [ID_W-1:0] ID_BLOCK        = 32'h0000_00a1;
  localparam logic [ID_W-1:0] ID_SIMPLE_BLOCK = 32'h0000_00a3;
  localparam logic [ID_W-1:0] ID_EBML_HEAD    = 32'h1a45_dfa3;
  localparam logic [ID_W-1:0] ID_SEGMENT      = 32'h1853_8067;
  localparam logic [ID_W-1:0] ID_INFO         = 32'h1549_a966;
  localparam logic [ID_W-1:0] ID_TRACKS       = 32'h1654_ae6b;
  localparam logic [ID_W-1:0] ID_TRACK_ENTRY  = 32'h0000_00ae;
  localparam logic [ID_W-1:0] ID_CLUSTER      = 32'h1f43_b675;
  localparam logic [ID_W-1:0] ID_CLUSTER_TIME = 32'h0000_00e7;
  localparam logic [ID_W-1:0] ID_TRACK_NUMBER = 32'h0000_00d7;

  typedef enum logic [3:0] {
    PH_ID_FIRST,
    PH_ID_REST,
    PH_SIZE_FIRST,
    PH_SIZE_REST,
    PH_SKIP,
    PH_INT,
    PH_TRACK_FIRST,
    PH_TRACK_REST,
    PH_TIME
  } phase_t;

  typedef enum logic [1:0] {
    EV_BLOCK = 2'd0,
    EV_TRACK = 2'd1,
    EV_END   = 2'd2,
    EV_ERROR = 2'd3
  } event_kind_t;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_BAD_ID    = 3'd1,
    ERR_BAD_SIZE  = 3'd2,
    ERR_TRUNCATED = 3'd3,
    ERR_INT_LARGE = 3'd4,
    ERR_TOO_DEEP  = 3'd5,
    ERR_OVERRUN   = 3'd6
  } error_code_t;

  // one command per cycle to the nesting stack
  typedef struct packed {
    logic             push;
    logic             pop_check;
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] push_end;
  } stack_cmd_t;

  // leading zeros plus one, zero for a zero byte
  function automatic logic [3:0] vint_len(input logic [7:0] b);
    logic [3:0] n;
    n = 4'd0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) n = 4'(8 - i);
    end
    return n;
  endfunction

  function automatic logic is_container(input logic [ID_W-1:0] id);
    return id == ID_BLOCK_GROUP || id == ID_EBML_HEAD || id == ID_SEGMENT ||
           id == ID_INFO || id == ID_TRACKS || id == ID_TRACK_ENTRY ||
           id == ID_CLUSTER;
  endfunction

endpackage

FILE: hdl/ebml_stream_element_parser_core.sv
// EBML / Matroska element parser.
// Input: one file byte per transaction on in_tdata[7:0]; in_tuser high
// marks end of stream instead of a byte. Output: one event per
// transaction: kind on out_tuser, track number, timecode, nesting level
// and error code on out_tdata.
// Throughput: one byte per cycle while the output is not held. Each byte
// passes a single stage of header, stack and payload logic into the
// output register, so an event appears on the output in the cycle after
// its byte is accepted. The output register frees in_tready whenever it
// is empty or being drained, so input stalls only while an event waits.
// Receiver stall: a held event stops input only until it is taken.
// Reset (synchronous, rst_n low) clears position, parse phase, nesting
// count and the stopped flag; the nesting stack entries need no clearing.
// After an end event or an error the block accepts and drops every byte
// until the next reset.
module ebml_stream_element_parser_core import ebml_pkg::*; #(
  parameter int MAX_DEPTH = EBML_MAX_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] byte_value
  input  logic        in_tuser,   // [0] end_of_stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata,  // [55:0] track_number, [87:56] timecode,
                                  // [91:88] nesting_level, [94:92] error_code
  output logic [1:0]  out_tuser   // [1:0] event_kind
);

  localparam int CW = $clog2(MAX_DEPTH + 1);

  phase_t              phase_r, phase_nxt;
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic [ACC_W-1:0]    acc_r, acc_nxt;
  logic [LEFT_W-1:0]   left_r, left_nxt;
  logic [ID_W-1:0]     id_r, id_nxt;
  logic [POS_W-1:0]    elem_end_r, elem_end_nxt;
  logic [TIME_W-1:0]   ctime_r, ctime_nxt;
  logic [ACC_W-1:0]    track_r, track_nxt;
  logic                stopped_r, stopped_nxt;

  logic                out_valid_r;
  event_kind_t         ev_kind_r;
  logic [ACC_W-1:0]    ev_track_r;
  logic [TIME_W-1:0]   ev_time_r;
  logic [3:0]          ev_lvl_r;
  error_code_t         ev_err_r;

  logic                ev_valid;
  event_kind_t         ev_kind;
  logic [ACC_W-1:0]    ev_track;
  logic [TIME_W-1:0]   ev_time;
  error_code_t         ev_err;

  logic                in_fire;
  logic [7:0]          b;
  logic [3:0]          n;
  logic [7:0]          masked;
  logic [ACC_W-1:0]    acc_sh;
  logic [LEFT_W-1:0]   left_dec;
  logic [POS_W-1:0]    pos_inc;
  logic [POS_W-1:0]    remaining;
  logic                hdr_do;
  logic [ACC_W-1:0]    hdr_size;
  logic [POS_W:0]      end_sum;
  logic [POS_W-1:0]    end_sat;
  logic                int_do;
  logic [ACC_W-1:0]    int_val;

  stack_cmd_t          scmd;
  logic [CW-1:0]       depth;
  logic [POS_W-1:0]    top_end;
  logic                full;

  assign in_fire   = in_tvalid && in_tready;
  assign in_tready = !out_valid_r || out_tready;
  assign b         = in_tdata;
  assign n         = vint_len(b);
  assign masked    = b & ~(8'h80 >> (n - 4'd1));
  assign acc_sh    = {acc_r[ACC_W-9:0], b};
  assign left_dec  = left_r - LEFT_W'(1);
  assign pos_inc   = pos_r + POS_W'(1);
  assign remaining = elem_end_r - pos_r;
  assign end_sum   = {1'b0, pos_inc} + {{(POS_W + 1 - ACC_W){1'b0}}, hdr_size};
  assign end_sat   = end_sum[POS_W] ? '1 : end_sum[POS_W-1:0];

  // per-byte parse step
  always_comb begin
    phase_nxt    = phase_r;
    pos_nxt      = pos_r;
    acc_nxt      = acc_r;
    left_nxt     = left_r;
    id_nxt       = id_r;
    elem_end_nxt = elem_end_r;
    ctime_nxt    = ctime_r;
    track_nxt    = track_r;
    stopped_nxt  = stopped_r;
    ev_valid     = 1'b0;
    ev_kind      = EV_BLOCK;
    ev_track     = '0;
    ev_time      = '0;
    ev_err       = ERR_NONE;
    hdr_do       = 1'b0;
    hdr_size     = '0;
    int_do       = 1'b0;
    int_val      = '0;
    scmd         = '0;
    scmd.pos     = pos_inc;
    scmd.push_end = end_sat;

    if (in_fire && !stopped_r) begin
      if (in_tuser) begin
        stopped_nxt = 1'b1;
        ev_valid    = 1'b1;
        if (phase_r == PH_ID_FIRST || phase_r == PH_SKIP) begin
          ev_kind = EV_END;
        end else begin
          ev_kind = EV_ERROR;
          ev_err  = ERR_TRUNCATED;
        end
      end else begin
        pos_nxt = pos_inc;
        case (phase_r)
          PH_ID_FIRST: begin
            if (n == 4'd0 || n > 4'd4) begin
              ev_valid = 1'b1; ev_kind = EV_ERROR; ev_err = ERR_BAD_ID;
            end else begin
              acc_nxt  = ACC_W'(b);
              left_nxt = LEFT_W'(n - 4'd1);
              if (n == 4'd1) begin
                id_nxt    = ID_W'(b);
                phase_nxt = PH_SIZE_FIRST;
              end else begin
                phase_nxt = PH_ID_REST;
              end
            end
          end
          PH_ID_REST: begin
            acc_nxt  = acc_sh;
            left_nxt = left_dec;
            if (left_dec == '0) begin
              id_nxt    = acc_sh[ID_W-1:0];
              phase_nxt = PH_SIZE_FIRST;
            end
          end
          PH_SIZE_FIRST: begin
            if (n == 4'd0) begin
              ev_valid = 1'b1; ev_kind = EV_ERROR; ev_err = ERR_BAD_SIZE;
            end else begin
              acc_nxt  = ACC_W'(masked);
              left_nxt = LEFT_W'(n - 4'd1);
              if (n == 4'd1) begin
                hdr_do   = 1'b1;
                hdr_size = ACC_W'(masked);
              end else begin
                phase_nxt = PH_SIZE_REST;
              end
            end
          end
          PH_SIZE_REST: begin
            acc_nxt  = acc_sh;
            left_nxt = left_dec;
            if (left_dec == '0) begin
              hdr_do   = 1'b1;
              hdr_size = acc_sh;
            end
          end
          PH_SKIP: begin
            if (pos_inc == elem_end_r) begin
              scmd.pop_check = 1'b1;
              phase_nxt      = PH_ID_FIRST;
            end
          end
          PH_INT: begin
            acc_nxt  = acc_sh;
            left_nxt = left_dec;
            if (left_dec == '0) begin
              int_do  = 1'b1;
              int_val = acc_sh;
            end
          end
          PH_TRACK_FIRST: begin
            if (n == 4'd0) begin
              ev_valid = 1'b1; ev_kind = EV_ERROR; ev_err = ERR_BAD_SIZE;
            end else if (POS_W'(n) + POS_W'(2) > remaining) begin
              ev_valid = 1'b1; ev_kind = EV_ERROR; ev_err = ERR_OVERRUN;
            end else if (n == 4'd1) begin
              track_nxt = ACC_W'(masked);
              acc_nxt   = '0;
              left_nxt  = LEFT_W'(2);
              phase_nxt = PH_TIME;
            end else begin
              acc_nxt   = ACC_W'(masked);
              left_nxt  = LEFT_W'(n - 4'd1);
              phase_nxt = PH_TRACK_REST;
            end
          end
          PH_TRACK_REST: begin
            acc_nxt  = acc_sh;
            left_nxt = left_dec;
            if (left_dec == '0) begin
              track_nxt = acc_sh;
              acc_nxt   = '0;
              left_nxt  = LEFT_W'(2);
              phase_nxt = PH_TIME;
            end
          end
          PH_TIME: begin
            acc_nxt  = acc_sh;
            left_nxt = left_dec;
            if (left_dec == '0) begin
              ev_valid = 1'b1;
              ev_kind  = EV_BLOCK;
              ev_track = track_r;
              ev_time  = ctime_r + TIME_W'(acc_sh[15:0]);
              if (pos_inc == elem_end_r) begin
                scmd.pop_check = 1'b1;
                phase_nxt      = PH_ID_FIRST;
              end else begin
                phase_nxt = PH_SKIP;
              end
            end
          end
          default: phase_nxt = PH_ID_FIRST;
        endcase

        // element header complete: classify the element
        if (hdr_do) begin
          elem_end_nxt = end_sat;
          if (depth != '0 && end_sat > top_end) begin
            ev_valid = 1'b1; ev_kind = EV_ERROR; ev_err = ERR_OVERRUN;
          end else if (is_container(id_r)) begin
            if (full) begin
              ev_valid = 1'b1; ev_kind = EV_ERROR; ev_err = ERR_TOO_DEEP;
            end else begin
              scmd.push      = 1'b1;
              scmd.pop_check = 1'b1;
              phase_nxt      = PH_ID_FIRST;
            end
          end else if (id_r == ID_BLOCK || id_r == ID_SIMPLE_BLOCK) begin
            if (hdr_size < ACC_W'(3)) begin
              ev_valid = 1'b1; ev_kind = EV_ERROR; ev_err = ERR_OVERRUN;
            end else begin
              phase_nxt = PH_TRACK_FIRST;
            end
          end else if (id_r == ID_CLUSTER_TIME || id_r == ID_TRACK_NUMBER) begin
            if (hdr_size > ACC_W'(4)) begin
              ev_valid = 1'b1; ev_kind = EV_ERROR; ev_err = ERR_INT_LARGE;
            end else begin
              acc_nxt  = '0;
              left_nxt = hdr_size[LEFT_W-1:0];
              if (hdr_size == '0) begin
                int_do  = 1'b1;
                int_val = '0;
              end else begin
                phase_nxt = PH_INT;
              end
            end
          end else if (hdr_size == '0) begin
            scmd.pop_check = 1'b1;
            phase_nxt      = PH_ID_FIRST;
          end else begin
            phase_nxt = PH_SKIP;
          end
        end

        // integer field complete: latch cluster time or report track
        if (int_do) begin
          scmd.pop_check = 1'b1;
          phase_nxt      = PH_ID_FIRST;
          if (id_r == ID_CLUSTER_TIME) begin
            ctime_nxt = int_val[TIME_W-1:0];
          end else begin
            ev_valid = 1'b1;
            ev_kind  = EV_TRACK;
            ev_track = int_val;
          end
        end

        if (ev_valid && ev_kind == EV_ERROR) stopped_nxt = 1'b1;
      end
    end
  end

  ebml_nest_stack #(
    .MAX_DEPTH(MAX_DEPTH)
  ) u_stack (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd_en  (in_fire && !stopped_nxt),
    .cmd     (scmd),
    .count   (depth),
    .top_end (top_end),
    .full    (full)
  );

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_ID_FIRST;
      pos_r      <= '0;
      acc_r      <= '0;
      left_r     <= '0;
      id_r       <= '0;
      elem_end_r <= '0;
      ctime_r    <= '0;
      track_r    <= '0;
      stopped_r  <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      pos_r      <= pos_nxt;
      acc_r      <= acc_nxt;
      left_r     <= left_nxt;
      id_r       <= id_nxt;
      elem_end_r <= elem_end_nxt;
      ctime_r    <= ctime_nxt;
      track_r    <= track_nxt;
      stopped_r  <= stopped_nxt;
    end
  end

  // output register: load a new event, drop a taken one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ev_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ev_valid) begin
      ev_kind_r  <= ev_kind;
      ev_track_r <= ev_track;
      ev_time_r  <= ev_time;
      ev_lvl_r   <= 4'(depth);
      ev_err_r   <= ev_err;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = ev_kind_r;
  assign out_tdata  = {1'b0, ev_err_r, ev_lvl_r, ev_time_r, ev_track_r};

`ifndef SYNTHESIS
  a_stopped_silent: assert property (@(posedge clk) disable iff (!rst_n)
    stopped_r |-> !ev_valid) else $error("event after stop");
  a_stopped_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    stopped_r |=> stopped_r) else $error("stop flag cleared without reset");
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_tready) else $error("input stalled with empty output");
  a_final_event_stops: assert property (@(posedge clk) disable iff (!rst_n)
    ev_valid && (ev_kind == EV_ERROR || ev_kind == EV_END) |=> stopped_r)
    else $error("terminal event did not stop parser");
`endif

endmodule

FILE: hdl/ebml_nest_stack.sv
module ebml_nest_stack import ebml_pkg::*; #(
  parameter int MAX_DEPTH = EBML_MAX_DEPTH,
  localparam int CW = $clog2(MAX_DEPTH + 1),
  localparam int IW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cmd_en,
  input  stack_cmd_t       cmd,
  output logic [CW-1:0]    count,
  output logic [POS_W-1:0] top_end,
  output logic             full
);

  logic [POS_W-1:0] ends_r [MAX_DEPTH];
  logic [CW-1:0]    cnt_r;
  logic [CW-1:0]    cnt_nxt;
  logic [CW-1:0]    cnt_push;
  logic [CW-1:0]    cnt_top;
  logic [POS_W-1:0] eff_end [MAX_DEPTH];

  assign cnt_push = (cmd_en && cmd.push) ? cnt_r + CW'(1) : cnt_r;
  assign cnt_top  = cnt_r - CW'(1);

  // see the entry being pushed this cycle so it can pop at once
  always_comb begin
    for (int i = 0; i < MAX_DEPTH; i++) begin
      eff_end[i] = (cmd.push && cnt_r == CW'(i)) ? cmd.push_end : ends_r[i];
    end
  end

  // pop every open container that ends at the current position
  always_comb begin
    cnt_nxt = cnt_push;
    if (cmd_en && cmd.pop_check) begin
      cnt_nxt = '0;
      for (int i = 0; i < MAX_DEPTH; i++) begin
        if (CW'(i) < cnt_push && eff_end[i] != cmd.pos) cnt_nxt = CW'(i + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // end positions carry no reset
  always_ff @(posedge clk) begin
    if (cmd_en && cmd.push && !full) begin
      ends_r[cnt_r[IW-1:0]] <= cmd.push_end;
    end
  end

  assign count   = cnt_r;
  assign top_end = ends_r[cnt_top[IW-1:0]];
  assign full    = (cnt_r == CW'(MAX_DEPTH));

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_DEPTH)) else $error("nesting count above depth");
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_en && cmd.push |-> !full) else $error("push into full stack");
  a_pop_only_down: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_en && cmd.pop_check && !cmd.push |=> cnt_r <= $past(cnt_r))
    else $error("pop raised the count");
`endif

endmodule
